### rtl/b64sp_pkg.sv
// ----------------------------------------------------------------------------
// b64sp_pkg
// Shared types, character codes and the base64 symbol lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package b64sp_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'

   // Group sizes
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_TWO   = 2'd2;
   localparam logic [1:0] COUNT_THREE = 2'd3;

   // Character slot within one emitted group
   typedef enum logic [2:0] {
      POS_SYM0 = 3'd0,
      POS_SYM1 = 3'd1,
      POS_SYM2 = 3'd2,
      POS_SYM3 = 3'd3,
      POS_TERM = 3'd4
   } char_pos_type;

   // One gathered group ready for output
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] count;  // valid bytes, 1..3
      logic       last;   // terminator follows
   } group_type;

   function automatic logic [7:0] symbol(input logic [5:0] v);
      logic [7:0] ch;
      case (v) inside
         [6'd0:6'd25]:  ch = CHAR_UPPER + 8'(v);
         [6'd26:6'd51]: ch = CHAR_LOWER + 8'(v - 6'd26);
         [6'd52:6'd61]: ch = CHAR_DIGIT + 8'(v - 6'd52);
         6'd62:         ch = CHAR_PLUS;
         default:       ch = CHAR_SLASH;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/b64sp_if.sv
// ----------------------------------------------------------------------------
// b64sp_if
// Valid/ready channels for raw bytes in and text characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64sp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64sp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       final_char;

   modport source (output valid, output text_char, output final_char, input ready);
   modport sink   (input valid, input text_char, input final_char, output ready);
endinterface

`default_nettype wire

### rtl/b64sp_gather.sv
// ----------------------------------------------------------------------------
// b64sp_gather
// Collects request bytes into groups of up to three and hands them on.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sp_gather (
   input  wire logic          clock,
   input  wire logic          reset,
   b64sp_req_if.sink          req,
   input  wire logic          slot_take,
   output logic               slot_valid,
   output b64sp_pkg::group_type slot
);

   logic [15:0]          pend_bytes_ff, pend_bytes_in;
   logic [1:0]           pend_cnt_ff, pend_cnt_in;
   logic                 slot_valid_ff, slot_valid_in;
   b64sp_pkg::group_type slot_ff, slot_in;
   logic                 accept;

   assign req.ready  = !slot_valid_ff || slot_take;
   assign accept     = req.valid && req.ready;
   assign slot_valid = slot_valid_ff;
   assign slot       = slot_ff;

   always_comb begin
      pend_bytes_in = pend_bytes_ff;
      pend_cnt_in   = pend_cnt_ff;
      slot_valid_in = slot_valid_ff && !slot_take;
      slot_in       = slot_ff;
      if (accept) begin
         if (pend_cnt_ff[1]) begin
            // third byte: group complete
            slot_valid_in = 1'b1;
            slot_in.b0    = pend_bytes_ff[15:8];
            slot_in.b1    = pend_bytes_ff[7:0];
            slot_in.b2    = req.data_byte;
            slot_in.count = b64sp_pkg::COUNT_THREE;
            slot_in.last  = req.end_of_message;
            pend_cnt_in   = 2'd0;
            pend_bytes_in = 16'd0;
         end else if (req.end_of_message) begin
            // short group closed by the last byte
            slot_valid_in = 1'b1;
            slot_in.b2    = 8'd0;
            slot_in.last  = 1'b1;
            if (pend_cnt_ff == 2'd0) begin
               slot_in.b0    = req.data_byte;
               slot_in.b1    = 8'd0;
               slot_in.count = b64sp_pkg::COUNT_ONE;
            end else begin
               slot_in.b0    = pend_bytes_ff[15:8];
               slot_in.b1    = req.data_byte;
               slot_in.count = b64sp_pkg::COUNT_TWO;
            end
            pend_cnt_in   = 2'd0;
            pend_bytes_in = 16'd0;
         end else begin
            if (pend_cnt_ff == 2'd0) begin
               pend_bytes_in = {req.data_byte, 8'd0};
            end else begin
               pend_bytes_in = {pend_bytes_ff[15:8], req.data_byte};
            end
            pend_cnt_in = pend_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= 16'd0;
         pend_cnt_ff   <= 2'd0;
         slot_valid_ff <= 1'b0;
      end else begin
         pend_bytes_ff <= pend_bytes_in;
         pend_cnt_ff   <= pend_cnt_in;
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

### rtl/b64sp_emit.sv
// ----------------------------------------------------------------------------
// b64sp_emit
// Turns a gathered group into four characters and an optional terminator.
// ----------------------------------------------------------------------------
`default_nettype none

module b64sp_emit (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            slot_valid,
   input  wire b64sp_pkg::group_type slot,
   output logic                 slot_take,
   b64sp_rsp_if.source          rsp
);

   b64sp_pkg::group_type     cur_ff, cur_in;
   b64sp_pkg::char_pos_type  pos_ff, pos_in;
   logic                     busy_ff, busy_in;
   logic                     fire, done;

   assign fire      = busy_ff && rsp.ready;
   assign done      = fire && ((pos_ff == b64sp_pkg::POS_SYM3 && !cur_ff.last)
                               || pos_ff == b64sp_pkg::POS_TERM);
   assign slot_take = slot_valid && (!busy_ff || done);
   assign rsp.valid = busy_ff;

   always_comb begin
      rsp.final_char = 1'b0;
      case (pos_ff)
         b64sp_pkg::POS_SYM0: rsp.text_char = b64sp_pkg::symbol(cur_ff.b0[7:2]);
         b64sp_pkg::POS_SYM1:
            rsp.text_char = b64sp_pkg::symbol({cur_ff.b0[1:0], cur_ff.b1[7:4]});
         b64sp_pkg::POS_SYM2:
            rsp.text_char = (cur_ff.count == b64sp_pkg::COUNT_ONE) ? b64sp_pkg::CHAR_SPACE
                          : b64sp_pkg::symbol({cur_ff.b1[3:0], cur_ff.b2[7:6]});
         b64sp_pkg::POS_SYM3:
            rsp.text_char = (cur_ff.count == b64sp_pkg::COUNT_THREE)
                          ? b64sp_pkg::symbol(cur_ff.b2[5:0]) : b64sp_pkg::CHAR_SPACE;
         default: begin
            rsp.text_char  = b64sp_pkg::CHAR_DASH;
            rsp.final_char = 1'b1;
         end
      endcase
   end

   always_comb begin
      cur_in  = cur_ff;
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (slot_take) begin
         cur_in  = slot;
         pos_in  = b64sp_pkg::POS_SYM0;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (fire) begin
         pos_in = b64sp_pkg::char_pos_type'(pos_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= b64sp_pkg::POS_SYM0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

### rtl/base64_space_pad_encoder.sv
// ----------------------------------------------------------------------------
// base64_space_pad_encoder
// Streaming base64 encoder with space padding and a '-' terminator.
// ----------------------------------------------------------------------------
// Bytes arrive one per request; end_of_message marks the last. Each group of
// three bytes leaves as four base64 characters (A-Z, a-z, 0-9, '+', '/'). A
// short final group is filled out with spaces instead of '=', and every
// message closes with a '-' character flagged by final_char. Requests are
// taken every cycle while a group slot is free; the result port sends one
// character per cycle while ready is high, so a full group of three bytes
// leaves as four result characters, with one more for the terminator. A
// group slot between the gatherer and the emitter lets the next group
// collect while the current one is still being sent.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_space_pad_encoder (
   input  wire logic   clock,
   input  wire logic   reset,
   b64sp_req_if.sink   req,
   b64sp_rsp_if.source rsp
);

   logic                 slot_valid;
   logic                 slot_take;
   b64sp_pkg::group_type slot;

   // byte gathering and the hand-over slot
   b64sp_gather u_gather (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .slot_take  (slot_take),
      .slot_valid (slot_valid),
      .slot       (slot)
   );

   // character sequencing onto the result port
   b64sp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .slot_valid (slot_valid),
      .slot       (slot),
      .slot_take  (slot_take),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

### bench/base64_space_pad_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_space_pad_encoder_test
// Self-checking bench for the space-padded base64 encoder.
// ----------------------------------------------------------------------------
// Byte requests go in as whole messages (last byte flagged). A small tracker
// keeps its own copy of the pending group and builds the characters due out:
// four symbols per full group, a space-filled short group on the last byte,
// then the '-' terminator. Every character taken from the result port is
// matched against the oldest one due. Both ports idle in random bursts until
// the closing stretch of the run, which runs flat out.
// ----------------------------------------------------------------------------

module base64_space_pad_encoder_test;

   localparam int CLOCK_HALF  = 5;
   localparam int RESET_TICKS = 8;
   localparam int RANDOM_ITEMS = 350;
   localparam int CALM_AFTER  = 300;      // random items before idling stops
   localparam int DRAIN_TICKS = 16;       // settle time once nothing is due
   localparam int TICK_LIMIT  = 200000;   // watchdog

   // One character as it should leave the result port
   typedef struct packed {
      logic [7:0] text_char;
      logic       final_char;
   } text_item_type;

   // -------------------------------------------------------------------------
   // Tracker: mirrors the group gathering and holds the characters still due.
   // -------------------------------------------------------------------------
   class encoded_text_tracker_type;
      logic [15:0]   held_bytes;     // first byte in 15..8, second in 7..0
      logic [1:0]    held_count;
      text_item_type due_chars[$];
      int            errors;
      string         alphabet;

      function new();
         held_bytes = '0;
         held_count = '0;
         errors     = 0;
         alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      endfunction

      function logic [7:0] sextet_char(logic [5:0] v);
         return alphabet[v];
      endfunction

      function void queue_char(logic [7:0] ch, logic fin);
         text_item_type item;
         item.text_char  = ch;
         item.final_char = fin;
         due_chars.push_back(item);
      endfunction

      // Accepted byte request: update held group, queue any characters due
      function void take_byte(logic [7:0] b, logic eom);
         logic [7:0] b0, b1, b2;
         logic [1:0] n;
         // a held count of three cannot arise; treat it as two regardless
         if (held_count >= b64sp_pkg::COUNT_TWO) begin
            b0 = held_bytes[15:8]; b1 = held_bytes[7:0]; b2 = b;
            n  = b64sp_pkg::COUNT_THREE;
         end else if (held_count == b64sp_pkg::COUNT_ONE) begin
            b0 = held_bytes[15:8]; b1 = b; b2 = '0;
            n  = b64sp_pkg::COUNT_TWO;
         end else begin
            b0 = b; b1 = '0; b2 = '0;
            n  = b64sp_pkg::COUNT_ONE;
         end
         if (n == b64sp_pkg::COUNT_THREE || eom) begin
            // missing bytes count as zero in the straddling symbol
            queue_char(sextet_char(b0[7:2]), 1'b0);
            queue_char(sextet_char({b0[1:0], b1[7:4]}), 1'b0);
            queue_char((n >= b64sp_pkg::COUNT_TWO) ? sextet_char({b1[3:0], b2[7:6]})
                                                    : b64sp_pkg::CHAR_SPACE, 1'b0);
            queue_char((n == b64sp_pkg::COUNT_THREE) ? sextet_char(b2[5:0])
                                                      : b64sp_pkg::CHAR_SPACE, 1'b0);
            if (eom)
               queue_char(b64sp_pkg::CHAR_DASH, 1'b1);
            held_bytes = '0;
            held_count = '0;
         end else begin
            held_bytes = (n == b64sp_pkg::COUNT_ONE) ? {b, 8'h00} : {held_bytes[15:8], b};
            held_count = n;
         end
      endfunction

      // Accepted result: compare with the oldest character due
      function void match_char(logic [7:0] ch, logic fin);
         text_item_type want;
         if (due_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected char %h final %b, nothing due", $time, ch, fin);
            return;
         end
         want = due_chars.pop_front();
         if (want.text_char !== ch) begin
            errors++;
            $display("%0t: text_char expected %h, actual %h", $time, want.text_char, ch);
         end
         if (want.final_char !== fin) begin
            errors++;
            $display("%0t: final_char expected %b, actual %b", $time, want.final_char, fin);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels, block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;      // no idling on either side once set
   int   ticks = 0;
   int   random_sent = 0;

   b64sp_req_if req_bus ();
   b64sp_rsp_if rsp_bus ();

   encoded_text_tracker_type tracker = new();

   base64_space_pad_encoder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      ticks <= ticks + 1;
      if (ticks > TICK_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: ready stalls in bursts, characters checked at rising edges
   // -------------------------------------------------------------------------
   int stall_left = 0;

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left    = $urandom_range(1, 5) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         tracker.match_char(rsp_bus.text_char, rsp_bus.final_char);
   end

   // -------------------------------------------------------------------------
   // Request side. Tasks are entered and left at a falling edge.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eom);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          = 1'b1;
      req_bus.data_byte      = b;
      req_bus.end_of_message = eom;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.take_byte(b, eom);
      @(negedge clock);
   endtask

   task automatic send_message(input logic [7:0] bytes[$]);
      foreach (bytes[i])
         send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // Random message: mostly short, now and then long; bytes lean on extremes
   task automatic send_random_message();
      logic [7:0] bytes[$];
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      repeat (len) begin
         case ($urandom_range(0, 9))
            0:       bytes.push_back(8'h00);
            1:       bytes.push_back(8'hFF);
            default: bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      send_message(bytes);
      random_sent += len;
   endtask

   initial begin
      req_bus.valid          = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.end_of_message = 1'b0;

      repeat (RESET_TICKS) @(negedge clock);
      reset = 1'b0;

      // Directed: one, two and three byte groups, extremes, '+' and '/'
      send_message({8'h00});                           // "AA  -"
      send_message({8'hFF});                           // "/w  -"
      send_message({8'hFF, 8'hFF});                    // "//8 -"
      send_message({8'h00, 8'h00, 8'h00});             // exact group
      send_message({8'hFF, 8'hFF, 8'hFF});             // all '/'
      send_message({8'hFB, 8'hEF, 8'hBE, 8'h4D});      // all '+', then short
      send_message({8'h4D, 8'h61, 8'h6E, 8'h80, 8'h01});
      send_message({8'h01, 8'h02, 8'h03, 8'hFE, 8'hFD, 8'hFC});

      // Random messages; closing stretch runs without idling
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= CALM_AFTER)
            calm = 1'b1;
         send_random_message();
      end
      calm          = 1'b1;
      req_bus.valid = 1'b0;

      while (tracker.due_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      if (tracker.errors == 0 && tracker.due_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
